@@ src/acbc_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-CBC block cipher package
// Shared types, S-box tables and round functions of the AES datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package acbc_pkg;

    typedef logic [7:0] t_byte;
    typedef t_byte t_sbox [256];

    localparam t_sbox SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_sbox build_inv_sbox();
        t_sbox t;
        for (int j = 0; j < 256; j++) begin
            t[SBOX[j]] = 8'(j);
        end
        return t;
    endfunction

    localparam t_sbox INV_SBOX = build_inv_sbox();

    typedef enum logic [2:0] {
        CFG_KEY_SIZE, CFG_DECRYPT, CFG_KEY0, CFG_KEY1,
        CFG_KEY2, CFG_KEY3, CFG_IV_HIGH, CFG_IV_LOW
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0, KEY_192 = 2'd1, KEY_256 = 2'd2, KEY_RSVD = 2'd3
    } t_key_size;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_ISSUE, ST_ROUND, ST_DONE
    } t_state;

    typedef struct packed {
        logic      start;
        t_key_size size;
    } t_kx_ctl;

    typedef struct packed {
        logic         we;
        logic [3:0]   row;
        logic [127:0] data;
    } t_kx_wr;

    function automatic t_byte xtime(t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gmul(t_byte a, t_byte b);
        t_byte p;
        t_byte x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = xtime(x);
        end
        return p;
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inv);
        logic [127:0] t;
        for (int i = 0; i < 16; i++) begin
            t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    t[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
                end else begin
                    t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(logic [127:0] s, logic inv);
        logic [127:0] t;
        t_byte m0, m1, m2, m3, a0, a1, a2, a3;
        m0 = inv ? 8'd14 : 8'd2;
        m1 = inv ? 8'd11 : 8'd3;
        m2 = inv ? 8'd13 : 8'd1;
        m3 = inv ? 8'd9  : 8'd1;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t[127-32*c -: 8] = gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3);
            t[119-32*c -: 8] = gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2);
            t[111-32*c -: 8] = gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1);
            t[103-32*c -: 8] = gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ src/acbc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/acbc_keyexp.sv @@
// ----------------------------------------------------------------------------
// AES key expansion engine
// Produces one round key word per cycle and writes full 128-bit rows.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_keyexp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire acbc_pkg::t_kx_ctl i_ctl,
    input  wire logic [255:0]     i_key,
    output acbc_pkg::t_kx_wr      o_wr,
    output logic                  o_done
);
    import acbc_pkg::*;

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [5:0]   r_idx, n_idx;
    logic [2:0]   r_phase, n_phase;
    logic [7:0]   r_rcon, n_rcon;
    logic [1:0]   r_size, n_size;
    logic [31:0]  r_win [8];
    logic [95:0]  r_row;
    logic [3:0]   nk;
    logic [5:0]   last_idx;
    logic [31:0]  temp, word;

    always_comb begin
        nk       = 4'd4 + {1'b0, r_size, 1'b0};
        last_idx = {nk, 2'b00} + 6'd27;
        temp     = r_win[0];
        n_rcon   = r_rcon;
        if ({2'b00, r_idx} < {4'b0000, nk}) begin
            word = i_key[255 - 32*r_idx[2:0] -: 32];
        end else begin
            if (r_phase == 3'd0) begin
                temp   = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
                n_rcon = xtime(r_rcon);
            end else if (nk == 4'd8 && r_phase == 3'd4) begin
                temp = sub_word(r_win[0]);
            end
            word = temp ^ r_win[3'(nk - 4'd1)];
        end

        n_busy  = r_busy;
        n_done  = 1'b0;
        n_idx   = r_idx + 6'd1;
        n_phase = (r_phase == 3'(nk - 4'd1)) ? 3'd0 : r_phase + 3'd1;
        n_size  = r_size;
        if (!r_busy) begin
            n_rcon = 8'h01;
        end
        if (r_busy && r_idx == last_idx) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
        if (i_ctl.start) begin
            n_busy  = 1'b1;
            n_idx   = '0;
            n_phase = '0;
            n_rcon  = 8'h01;
            n_size  = (i_ctl.size == KEY_RSVD) ? KEY_256 : i_ctl.size;
        end

        o_wr.we   = r_busy && r_idx[1:0] == 2'd3;
        o_wr.row  = r_idx[5:2];
        o_wr.data = {r_row, word};
        o_done    = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_phase <= '0;
            r_rcon  <= 8'h01;
            r_size  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_rcon  <= n_rcon;
            r_size  <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_row <= {r_row[63:0], word};
        end
    end

endmodule

`default_nettype wire

@@ src/aes_cbc_block_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// AES-CBC block cipher unit
// AES-128/192/256 encryption and decryption in CBC mode, one block per beat.
// ----------------------------------------------------------------------------
// A beat is worked one round per cycle, fed by a round key memory that holds
// one 128-bit row per round and returns it as registered read data. A beat
// with tuser set first expands the key, one word per cycle, and reloads the
// chain from the IV. One block is in flight at a time because each block
// chains on the last.
`default_nettype none

module aes_cbc_block_cipher_unit #(
    parameter int MAX_ROUND_KEY_WORDS = 60
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [63:0]   i_cfg_wdata,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [127:0]  i_s_axis_tdata,  // block_high, block_low
    input  wire logic          i_s_axis_tuser,  // chain_restart
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [127:0]       o_m_axis_tdata   // result_high, result_low
);
    import acbc_pkg::*;

    localparam int ROWS = MAX_ROUND_KEY_WORDS / 4;
    localparam int AW   = $clog2(ROWS);

    t_state        r_state, n_state;
    logic [1:0]    r_key_size;
    logic          r_dec_cfg;
    logic [255:0]  r_key;
    logic [127:0]  r_iv;
    logic [3:0]    r_nr, n_nr;
    logic [127:0]  r_chain, n_chain;
    logic [127:0]  r_blk, n_blk;
    logic          r_dec, n_dec;
    logic [127:0]  r_s, n_s;
    logic [3:0]    r_rnd, n_rnd;
    logic          r_first, n_first;
    logic          r_out_valid, n_out_valid;
    logic [127:0]  r_out, n_out;
    logic          r_rd_zero;

    t_kx_ctl       kx_ctl;
    t_kx_wr        kx_wr;
    logic          kx_done;
    logic          rd_en;
    logic [3:0]    rd_row;
    logic [127:0]  ram_rdata, round_key, t;
    logic          last_round;

    acbc_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (kx_ctl),
        .i_key   (r_key),
        .o_wr    (kx_wr),
        .o_done  (kx_done)
    );

    acbc_ram #(
        .WIDTH (128),
        .DEPTH (ROWS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (kx_wr.we && {1'b0, kx_wr.row} < 5'(ROWS)),
        .i_waddr (AW'(kx_wr.row)),
        .i_wdata (kx_wr.data),
        .i_re    (rd_en && {1'b0, rd_row} < 5'(ROWS)),
        .i_raddr (AW'(rd_row)),
        .o_rdata (ram_rdata)
    );

    assign round_key       = r_rd_zero ? '0 : ram_rdata;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    always_comb begin
        n_state     = r_state;
        n_nr        = r_nr;
        n_chain     = r_chain;
        n_blk       = r_blk;
        n_dec       = r_dec;
        n_s         = r_s;
        n_rnd       = r_rnd;
        n_first     = r_first;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        kx_ctl.start = 1'b0;
        kx_ctl.size  = t_key_size'(r_key_size);
        rd_en       = 1'b0;
        rd_row      = r_rnd;
        t           = '0;
        last_round  = r_dec ? (r_rnd == 4'd0) : (r_rnd == r_nr && !r_first);

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_blk = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
                    n_dec = r_dec_cfg;
                    if (i_s_axis_tuser) begin
                        kx_ctl.start = 1'b1;
                        n_nr    = (r_key_size == KEY_RSVD) ? 4'd14
                                : 4'd10 + {1'b0, r_key_size, 1'b0};
                        n_chain = r_iv;
                        n_state = ST_EXPAND;
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_EXPAND: begin
                if (kx_done) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_s     = r_dec ? r_blk : r_blk ^ r_chain;
                rd_row  = r_dec ? r_nr : 4'd0;
                rd_en   = 1'b1;
                n_rnd   = rd_row;
                n_first = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_first) begin
                    t = r_s ^ round_key;
                end else if (r_dec) begin
                    t = sub_bytes(shift_rows(r_s, 1'b1), 1'b1) ^ round_key;
                    if (r_rnd != 4'd0) begin
                        t = mix_columns(t, 1'b1);
                    end
                end else begin
                    t = shift_rows(sub_bytes(r_s, 1'b0), 1'b0);
                    if (r_rnd != r_nr) begin
                        t = mix_columns(t, 1'b0);
                    end
                    t = t ^ round_key;
                end
                n_s     = t;
                n_first = 1'b0;
                rd_row  = r_dec ? r_rnd - 4'd1 : r_rnd + 4'd1;
                n_rnd   = rd_row;
                if (last_round) begin
                    n_state = ST_DONE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = r_dec ? r_s ^ r_chain : r_s;
                    n_chain     = r_dec ? r_blk : r_s;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_nr        <= 4'd10;
            r_chain     <= '0;
            r_key_size  <= '0;
            r_dec_cfg   <= 1'b0;
            r_key       <= '0;
            r_iv        <= '0;
            r_rd_zero   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_nr        <= n_nr;
            r_chain     <= n_chain;
            if (rd_en) begin
                r_rd_zero <= {1'b0, rd_row} >= 5'(ROWS);
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_KEY_SIZE: r_key_size      <= i_cfg_wdata[1:0];
                    CFG_DECRYPT:  r_dec_cfg       <= i_cfg_wdata[0];
                    CFG_KEY0:     r_key[255:192]  <= i_cfg_wdata;
                    CFG_KEY1:     r_key[191:128]  <= i_cfg_wdata;
                    CFG_KEY2:     r_key[127:64]   <= i_cfg_wdata;
                    CFG_KEY3:     r_key[63:0]     <= i_cfg_wdata;
                    CFG_IV_HIGH:  r_iv[127:64]    <= i_cfg_wdata;
                    CFG_IV_LOW:   r_iv[63:0]      <= i_cfg_wdata;
                    default:      r_iv            <= r_iv;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk   <= n_blk;
        r_dec   <= n_dec;
        r_s     <= n_s;
        r_rnd   <= n_rnd;
        r_first <= n_first;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

@@ src/acbc_checker.sv @@
// ----------------------------------------------------------------------------
// AES-CBC port checker
// Watches the stream ports of the cipher unit and checks their handshake rules.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [127:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Output beat changed while stalled.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("Input accepted while a block is in flight.");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> ##1 !$rose(o_m_axis_tvalid))
        else $error("Result appeared too soon after an input beat.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("Unit not idle after reset.");

endmodule

bind aes_cbc_block_cipher_unit acbc_checker u_acbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

@@ tb/aes_cbc_block_cipher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// AES-CBC block cipher unit testbench
// Drives 128-bit blocks through the unit with random idle cycles on both
// stream ports and checks each output block against an AES-CBC predictor
// kept in the bench, over all key sizes, both directions and chain restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_cbc_block_cipher_unit_tb;

    import acbc_pkg::*;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        restart;
    } t_block_beat;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_cipher_out;

    localparam int WATCHDOG_LIMIT = 5000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_addr = '0;
    logic [63:0]   i_cfg_wdata = '0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [127:0]  i_s_axis_tdata = '0;  // block_high, block_low
    logic          i_s_axis_tuser = 1'b0;  // chain_restart
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [127:0]  o_m_axis_tdata;  // result_high, result_low

    aes_cbc_block_cipher_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_block_beat  block_queue[$];
    t_cipher_out  cipher_expected[$];
    t_block_beat  beat_on_bus;
    int           send_idle_pct = 29;
    int           recv_idle_pct = 49;
    int           error_count = 0;
    int           blocks_sent = 0;
    int           blocks_checked = 0;
    int           quiet_cycles = 0;

    // Predictor state.
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [1:0]   key_size_reg = '0;
    logic         decrypt_reg = 1'b0;
    logic [63:0]  key_reg [4] = '{default: '0};
    logic [63:0]  iv_reg [2] = '{default: '0};
    logic [31:0]  sched_words [60];
    logic [63:0]  chain_reg [2] = '{default: '0};
    int           num_rounds = 10;
    logic [7:0]   st [16];

    function automatic logic [7:0] xt(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = xt(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    task automatic build_sub_tables();
        logic [7:0] b;
        logic [7:0] s;
        for (int v = 0; v < 256; v++) begin
            b = 8'h00;
            for (int c = 1; c < 256; c++) begin
                if (v != 0 && gf_mul(8'(v), 8'(c)) == 8'h01) b = 8'(c);
            end
            s = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
            fwd_sub[v] = s;
            inv_sub[s] = 8'(v);
        end
    endtask

    function automatic logic [31:0] sub_w(logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    task automatic expand_schedule();
        int nk;
        int total;
        logic [7:0] rc;
        logic [31:0] t;
        nk = 4 + 2 * ((key_size_reg == KEY_RSVD) ? 2 : int'(key_size_reg));
        num_rounds = nk + 6;
        total = 4 * (num_rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < total; i++) begin
            if (i < nk) begin
                sched_words[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
            end else begin
                t = sched_words[i - 1];
                if (i % nk == 0) begin
                    t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = xt(rc);
                end else if (nk > 6 && i % nk == 4) begin
                    t = sub_w(t);
                end
                sched_words[i] = t ^ sched_words[i - nk];
            end
        end
    endtask

    task automatic add_key(int r);
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
                st[4 * c + k] ^= sched_words[4 * r + c][31 - 8 * k -: 8];
    endtask

    task automatic sub_all(logic inv);
        for (int i = 0; i < 16; i++) st[i] = inv ? inv_sub[st[i]] : fwd_sub[st[i]];
    endtask

    task automatic shift_all(logic inv);
        logic [7:0] t [16];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                if (inv) t[r + 4 * ((c + r) % 4)] = st[r + 4 * c];
                else t[r + 4 * c] = st[r + 4 * ((c + r) % 4)];
            end
        st = t;
    endtask

    task automatic mix_all(logic inv);
        logic [7:0] m0, m1, m2, m3, a0, a1, a2, a3;
        m0 = inv ? 8'd14 : 8'd2;
        m1 = inv ? 8'd11 : 8'd3;
        m2 = inv ? 8'd13 : 8'd1;
        m3 = inv ? 8'd9 : 8'd1;
        for (int c = 0; c < 4; c++) begin
            a0 = st[4 * c]; a1 = st[4 * c + 1]; a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
            st[4 * c]     = gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3);
            st[4 * c + 1] = gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2);
            st[4 * c + 2] = gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1);
            st[4 * c + 3] = gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0);
        end
    endtask

    task automatic predict_cbc(t_block_beat b);
        t_cipher_out res;
        logic [127:0] v;
        if (b.restart) begin
            expand_schedule();
            chain_reg = iv_reg;
        end
        v = decrypt_reg ? {b.hi, b.lo} : {b.hi ^ chain_reg[0], b.lo ^ chain_reg[1]};
        for (int i = 0; i < 16; i++) st[i] = v[127 - 8 * i -: 8];
        if (!decrypt_reg) begin
            add_key(0);
            for (int r = 1; r < num_rounds; r++) begin
                sub_all(1'b0); shift_all(1'b0); mix_all(1'b0); add_key(r);
            end
            sub_all(1'b0); shift_all(1'b0); add_key(num_rounds);
        end else begin
            add_key(num_rounds);
            for (int r = num_rounds - 1; r >= 1; r--) begin
                shift_all(1'b1); sub_all(1'b1); add_key(r); mix_all(1'b1);
            end
            shift_all(1'b1); sub_all(1'b1); add_key(0);
        end
        for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = st[i];
        if (decrypt_reg) begin
            res.hi = v[127:64] ^ chain_reg[0];
            res.lo = v[63:0] ^ chain_reg[1];
            chain_reg[0] = b.hi;
            chain_reg[1] = b.lo;
        end else begin
            res.hi = v[127:64];
            res.lo = v[63:0];
            chain_reg[0] = res.hi;
            chain_reg[1] = res.lo;
        end
        cipher_expected.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_cbc(beat_on_bus);
                blocks_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (block_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    beat_on_bus = block_queue.pop_front();
                    i_s_axis_tdata <= {beat_on_bus.lo, beat_on_bus.hi};
                    i_s_axis_tuser <= beat_on_bus.restart;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cipher_out exp_out;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (cipher_expected.size() == 0) begin
                    $error("unexpected output block %h", o_m_axis_tdata);
                    error_count++;
                end else begin
                    exp_out = cipher_expected.pop_front();
                    blocks_checked++;
                    if (o_m_axis_tdata[63:0] !== exp_out.hi) begin
                        $error("result_high: expected %h, got %h", exp_out.hi,
                               o_m_axis_tdata[63:0]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[127:64] !== exp_out.lo) begin
                        $error("result_low: expected %h, got %h", exp_out.lo,
                               o_m_axis_tdata[127:64]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_KEY_SIZE: key_size_reg = value[1:0];
            CFG_DECRYPT:  decrypt_reg = value[0];
            CFG_KEY0:     key_reg[0] = value;
            CFG_KEY1:     key_reg[1] = value;
            CFG_KEY2:     key_reg[2] = value;
            CFG_KEY3:     key_reg[3] = value;
            CFG_IV_HIGH:  iv_reg[0] = value;
            CFG_IV_LOW:   iv_reg[1] = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (block_queue.size() > 0 || i_s_axis_tvalid || cipher_expected.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic queue_block(logic [63:0] hi, logic [63:0] lo, logic restart);
        t_block_beat b;
        b.hi = hi;
        b.lo = lo;
        b.restart = restart;
        block_queue.push_back(b);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int n_items;
        build_sub_tables();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Known-answer vectors: key 000102..1f cut to the key size, plaintext 00112233..ff, zero IV.
        write_reg(CFG_KEY0, 64'h0001020304050607);
        write_reg(CFG_KEY1, 64'h08090a0b0c0d0e0f);
        write_reg(CFG_KEY2, 64'h1011121314151617);
        write_reg(CFG_KEY3, 64'h18191a1b1c1d1e1f);
        write_reg(CFG_IV_HIGH, 64'h0);
        write_reg(CFG_IV_LOW, 64'h0);
        for (int ks = 0; ks < 4; ks++) begin
            write_reg(CFG_KEY_SIZE, 64'(ks));
            write_reg(CFG_DECRYPT, 64'd0);
            queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
            queue_block('1, '1, 1'b0);
            drain();
            write_reg(CFG_DECRYPT, 64'd1);
            queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
            queue_block(64'h0, 64'h0, 1'b0);
            drain();
        end
        // Direction flip with no restart keeps the latched key schedule.
        write_reg(CFG_IV_HIGH, '1);
        write_reg(CFG_IV_LOW, 64'haaaaaaaa55555555);
        write_reg(CFG_DECRYPT, 64'd0);
        queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
        queue_block(64'h0, 64'h0, 1'b0);
        drain();
        write_reg(CFG_KEY_SIZE, 64'(KEY_128));
        write_reg(CFG_DECRYPT, 64'd1);
        queue_block(64'h8000000000000001, 64'h0000000000000001, 1'b0);
        queue_block(64'h0, 64'h0, 1'b1);
        drain();

        for (int ph = 0; ph < 15; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 49;
                recv_idle_pct = 29;
            end else if (ph == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_DECRYPT, 64'($urandom_range(1)));
            if ($urandom_range(3) != 0) begin
                write_reg(CFG_KEY_SIZE, 64'($urandom_range(3)));
                write_reg(CFG_KEY0, rand64());
                write_reg(CFG_KEY1, rand64());
                write_reg(CFG_KEY2, rand64());
                write_reg(CFG_KEY3, rand64());
            end
            write_reg(CFG_IV_HIGH, rand64());
            write_reg(CFG_IV_LOW, rand64());
            n_items = 90 + $urandom_range(20);
            for (int k = 0; k < n_items; k++)
                queue_block(rand64(), rand64(), (k == 0) || ($urandom_range(11) == 0));
            drain();
        end

        $display("Checked %0d output blocks from %0d input blocks.", blocks_checked,
                 blocks_sent);
        $display("Covered 128/192/256-bit keys, the unused size code, both directions.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/acbc_pkg.sv
src/acbc_ram.sv
src/acbc_keyexp.sv
src/aes_cbc_block_cipher_unit.sv
src/acbc_checker.sv
tb/aes_cbc_block_cipher_unit_tb.sv
